// ----- rtl/assert_macros.svh -----
// Assertion shorthands used by the top level of the rasterizer.
// No dependencies; every macro samples clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent are checked in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/trab_pkg.sv -----
// Shared types, widths, register codes and arithmetic helpers of the rasterizer.
// Used by trab_mac, trab_fb and triangle_raster_alpha_blend_top; no dependencies.
`default_nettype none

package trab_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int REG_W = 9;    // size register width
  localparam int DIM_W = 13;   // effective size, holds up to 8191
  localparam int CRD_W = 14;   // signed pixel coordinate before clamping
  localparam int MA_W  = 18;   // shared multiplier, first operand
  localparam int MB_W  = 17;   // shared multiplier, second operand
  localparam int MP_W  = 35;   // shared multiplier, product
  localparam int EW    = 36;   // edge function values
  localparam int NW    = 36;   // blend numerator
  localparam int CH_W  = 16;   // color channel
  localparam int CNT_W = 17;   // covered pixel count
  localparam int IN_W  = 176;
  localparam int OUT_W = 88;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH  = 1'b0;
  localparam reg_idx_t REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  localparam pixel_t PIXEL_RESET = '{alpha: 16'hFFFF, blue: 16'h0000,
                                     green: 16'h0000, red: 16'h0000};

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
    logic signed [15:0] m;
    begin
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    end
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
    logic signed [15:0] m;
    begin
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
    end
  endfunction

  // Q11.4 to integer, rounding toward zero.
  function automatic logic signed [CRD_W-1:0] trunc_q4(input logic signed [15:0] v);
    logic signed [16:0] t;
    begin
      t = 17'(v);
      if (v < 0) begin
        t = t + 17'sd15;
      end
      return CRD_W'(t >>> 4);
    end
  endfunction

  // Finishes dst*(1-a)+src*a: prod is (src-dst)*a, the result is the rounded
  // quotient by 65535. The quotient estimate n>>16 is low by at most two.
  function automatic logic [CH_W-1:0] blend_div(input logic [CH_W-1:0] dst,
                                                input logic signed [MP_W-1:0] prod);
    logic signed [NW-1:0] n;
    logic [15:0] q0;
    logic [16:0] r;
    logic [16:0] q;
    begin
      n  = $signed({4'b0000, dst, 16'h0000}) - $signed({20'h00000, dst})
           + NW'(prod) + $signed(NW'(32767));
      q0 = n[31:16];
      r  = {1'b0, n[15:0]} + {1'b0, q0};
      if (r >= 17'd131070) begin
        q = {1'b0, q0} + 17'd2;
      end else if (r >= 17'd65535) begin
        q = {1'b0, q0} + 17'd1;
      end else begin
        q = {1'b0, q0};
      end
      return q[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/trab_mac.sv -----
// Shared signed multiplier with a registered product.
// Depends on trab_pkg for the operand and product widths.
`default_nettype none

module trab_mac (
  input  wire logic                             clk,
  input  wire logic signed [trab_pkg::MA_W-1:0] a,
  input  wire logic signed [trab_pkg::MB_W-1:0] b,
  output logic signed [trab_pkg::MP_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ----- rtl/trab_fb.sv -----
// Frame store: one pixel per entry, one access per cycle, registered read.
// Depends on trab_pkg for the pixel and command types.
`default_nettype none

module trab_fb #(
  parameter int DEPTH  = trab_pkg::MAX_WIDTH_DEF * trab_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_W = 16
) (
  input  wire logic                 clk,
  input  wire trab_pkg::mem_cmd_t   cmd,
  input  wire logic [ADDR_W-1:0]    addr,
  input  wire trab_pkg::pixel_t     wdata,
  output trab_pkg::pixel_t          rdata
);

  trab_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/triangle_raster_alpha_blend_top.sv -----
// Triangle rasterizer with alpha blending into an RGBA frame store; top level.
// Read beat: RD_MUL, RD_CHK, RD_LAT (not on a bad index), DONE; draw beat: BOX, SETUP,
// then PIX per pixel of the clamped box, BLEND per covered pixel (one shared multiplier).
// One beat is processed at a time; the next is taken once the result is registered.
// Reset (synchronous) starts a clearing pass of all MAX_WIDTH*MAX_HEIGHT pixels, one
// pixel a cycle, with no input beat accepted; configuration is taken while rst is low.
`default_nettype none
`include "assert_macros.svh"

module triangle_raster_alpha_blend_top #(
  parameter int MAX_WIDTH  = trab_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trab_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input beat.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // From bit 0: vx_a, vy_a, vx_b, vy_b, vx_c, vy_c, src_red, src_green,
  // src_blue, src_alpha, pixel_index; 16 bits each.
  input  wire logic [trab_pkg::IN_W-1:0]     s_axis_tdata,
  // Bit 0: mode (0 draw, 1 read).
  input  wire logic [0:0]                    s_axis_tuser,
  // Result beat.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // From bit 0: out_red, out_green, out_blue, out_alpha (16 bits each),
  // pixels_drawn (17 bits), then zero padding.
  output logic [trab_pkg::OUT_W-1:0]         m_axis_tdata,
  // Bit 0: bad_index.
  output logic [0:0]                         m_axis_tuser,
  // Configuration writes.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire trab_pkg::reg_idx_t            cfg_index,
  input  wire logic [trab_pkg::REG_W-1:0]    cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int EW   = trab_pkg::EW;
  localparam int MA_W = trab_pkg::MA_W;
  localparam int MB_W = trab_pkg::MB_W;
  localparam int MP_W = trab_pkg::MP_W;
  localparam int DIM_W = trab_pkg::DIM_W;
  localparam int CRD_W = trab_pkg::CRD_W;

  // The sequencer. CLEAR sweeps the store after reset. A read multiplies
  // width by height on the shared unit, checks the index and fetches the pixel
  // if the index is in range. A draw computes the box, runs the setup on the shared
  // unit (the edge products and the first row address), then walks the box. A covered
  // pixel is fetched in PIX and blended channel by channel in BLEND.
  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RD_MUL = 10'b0000000100,
    S_RD_CHK = 10'b0000001000,
    S_RD_LAT = 10'b0000010000,
    S_BOX    = 10'b0000100000,
    S_SETUP  = 10'b0001000000,
    S_PIX    = 10'b0010000000,
    S_BLEND  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [trab_pkg::IN_W-1:0]  item;
  logic [trab_pkg::REG_W-1:0] width_reg, height_reg;
  logic [DIM_W-1:0]           w_eff, h_eff;
  logic [ADDR_W-1:0]          clr_addr;
  logic [2:0]                 k, ch;
  logic [XW-1:0]              x0, x1, px;
  logic [YW-1:0]              y0, y1, py;
  logic [ADDR_W-1:0]          row_start, pix_addr;
  logic [trab_pkg::CNT_W-1:0] cnt;
  trab_pkg::pixel_t           res_pix;
  logic                       res_bad;
  logic [2:0][15:0]           newpix;

  logic signed [EW-1:0] e_row [3];
  logic signed [EW-1:0] e_cur [3];
  logic signed [EW-1:0] sx [3];
  logic signed [EW-1:0] sy [3];
  logic signed [MB_W-1:0] dy [3];
  logic signed [MB_W-1:0] dx [3];
  logic signed [15:0] org_x [3];
  logic signed [15:0] org_y [3];

  logic signed [15:0] vx_a, vy_a, vx_b, vy_b, vx_c, vy_c;
  logic [3:0][15:0]   src_arr;
  logic [15:0]        src_alpha, pixel_index;

  logic signed [MA_W-1:0] mac_a, xs0, ys0;
  logic signed [MB_W-1:0] mac_b;
  logic signed [MP_W-1:0] mac_p;

  trab_pkg::mem_cmd_t  mem_cmd;
  logic [ADDR_W-1:0]   mem_addr;
  trab_pkg::pixel_t    mem_wdata, mem_rdata;
  logic [3:0][15:0]    dst_arr;

  logic               accept, covered, last_x, last_y, advance, idx_bad, out_free;
  logic [1:0]         pc;
  logic [2:0]         kk;
  logic [1:0]         e_idx;
  logic signed [16:0] bl_diff;
  logic [15:0]        bl_new;
  logic [XW-1:0]      box_x0, box_x1;
  logic [YW-1:0]      box_y0, box_y1;

  // Truncated bound clamped into [0, size-1].
  function automatic logic [CRD_W-1:0] clamp_box(input logic signed [CRD_W-1:0] t,
                                                 input logic [DIM_W-1:0] size);
    logic signed [CRD_W-1:0] hi;
    begin
      hi = $signed({1'b0, size}) - $signed(CRD_W'(1));
      if (t < 0) begin
        return '0;
      end else if (t > hi) begin
        return hi;
      end else begin
        return t;
      end
    end
  endfunction

  // Fields of the held input beat.
  assign vx_a        = item[15:0];
  assign vy_a        = item[31:16];
  assign vx_b        = item[47:32];
  assign vy_b        = item[63:48];
  assign vx_c        = item[79:64];
  assign vy_c        = item[95:80];
  assign src_arr     = item[159:96];
  assign src_alpha   = item[159:144];
  assign pixel_index = item[175:160];

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // A size of zero acts as one, a size above the maximum as the maximum.
  always_comb begin
    if (width_reg == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(height_reg);
    end
  end

  // Bounding box of the triangle.
  assign box_x0 = XW'(clamp_box(trab_pkg::trunc_q4(trab_pkg::min3(vx_a, vx_b, vx_c)), w_eff));
  assign box_x1 = XW'(clamp_box(trab_pkg::trunc_q4(trab_pkg::max3(vx_a, vx_b, vx_c)), w_eff));
  assign box_y0 = YW'(clamp_box(trab_pkg::trunc_q4(trab_pkg::min3(vy_a, vy_b, vy_c)), h_eff));
  assign box_y1 = YW'(clamp_box(trab_pkg::trunc_q4(trab_pkg::max3(vy_a, vy_b, vy_c)), h_eff));

  // Edge i runs from org to the next vertex: edges B->C, C->A and A->B. Along
  // x each edge value grows by 16*dy, along y it falls by 16*dx.
  always_comb begin
    org_x[0] = vx_b;  org_y[0] = vy_b;
    org_x[1] = vx_c;  org_y[1] = vy_c;
    org_x[2] = vx_a;  org_y[2] = vy_a;
    dy[0] = MB_W'(vy_c) - MB_W'(vy_b);
    dy[1] = MB_W'(vy_a) - MB_W'(vy_c);
    dy[2] = MB_W'(vy_b) - MB_W'(vy_a);
    dx[0] = MB_W'(vx_c) - MB_W'(vx_b);
    dx[1] = MB_W'(vx_a) - MB_W'(vx_c);
    dx[2] = MB_W'(vx_b) - MB_W'(vx_a);
    for (int i = 0; i < 3; i++) begin
      sx[i] = EW'(dy[i]) <<< 4;
      sy[i] = -(EW'(dx[i]) <<< 4);
    end
  end

  assign xs0 = $signed(MA_W'({x0, 4'b0000}));
  assign ys0 = $signed(MA_W'({y0, 4'b0000}));

  // A pixel is covered when all edge values have the same sign.
  assign covered = (e_cur[0][EW-1] == e_cur[1][EW-1]) && (e_cur[1][EW-1] == e_cur[2][EW-1]);
  assign last_x  = (px == x1);
  assign last_y  = (py == y1);
  assign advance = ((state == S_PIX) && !covered) || ((state == S_BLEND) && (ch == 3'd4));
  assign idx_bad = MP_W'(pixel_index) >= $unsigned(mac_p);

  assign kk    = k - 3'd1;
  assign e_idx = kk[2:1];

  // Blending: channel ch goes into the multiplier, channel ch-1 comes out.
  assign dst_arr = mem_rdata;
  assign pc      = ch[1:0] - 2'd1;
  assign bl_diff = $signed({1'b0, src_arr[ch[1:0]]}) - $signed({1'b0, dst_arr[ch[1:0]]});
  assign bl_new  = trab_pkg::blend_div(dst_arr[pc], mac_p);

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    case (state)
      S_RD_MUL: begin
        mac_a = $signed(MA_W'(w_eff));
        mac_b = $signed(MB_W'(h_eff));
      end
      S_SETUP: begin
        case (k)
          3'd0, 3'd2, 3'd4: begin
            mac_a = xs0 - MA_W'(org_x[k[2:1]]);
            mac_b = dy[k[2:1]];
          end
          3'd1, 3'd3, 3'd5: begin
            mac_a = ys0 - MA_W'(org_y[k[2:1]]);
            mac_b = dx[k[2:1]];
          end
          3'd6: begin
            mac_a = $signed(MA_W'(y0));
            mac_b = $signed(MB_W'(w_eff));
          end
          default: begin
            mac_a = '0;
            mac_b = '0;
          end
        endcase
      end
      S_BLEND: begin
        mac_a = MA_W'(bl_diff);
        mac_b = $signed({1'b0, src_alpha});
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  trab_mac u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .p   (mac_p)
  );

  // Frame store access.
  always_comb begin
    mem_cmd   = '0;
    mem_addr  = pix_addr;
    mem_wdata = {bl_new, newpix[2], newpix[1], newpix[0]};
    case (state)
      S_CLEAR: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = clr_addr;
        mem_wdata  = trab_pkg::PIXEL_RESET;
      end
      S_RD_CHK: begin
        mem_cmd.rd = !idx_bad;
        mem_addr   = ADDR_W'(pixel_index);
      end
      S_PIX: begin
        mem_cmd.rd = covered;
      end
      S_BLEND: begin
        mem_cmd.wr = (ch == 3'd4);
      end
      default: begin
        mem_cmd = '0;
      end
    endcase
  end

  trab_fb #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_fb (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = s_axis_tuser[0] ? S_RD_MUL : S_BOX;
        end
      end
      S_RD_MUL: state_next = S_RD_CHK;
      S_RD_CHK: state_next = idx_bad ? S_DONE : S_RD_LAT;
      S_RD_LAT: state_next = S_DONE;
      S_BOX:    state_next = S_SETUP;
      S_SETUP: begin
        if (k == 3'd7) begin
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        if (covered) begin
          state_next = S_BLEND;
        end else if (last_x && last_y) begin
          state_next = S_DONE;
        end
      end
      S_BLEND: begin
        if (ch == 3'd4) begin
          state_next = (last_x && last_y) ? S_DONE : S_PIX;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
      width_reg     <= 9'd256;
      height_reg    <= 9'd256;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if ((state == S_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trab_pkg::REG_WIDTH:  width_reg  <= cfg_data;
          trab_pkg::REG_HEIGHT: height_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= s_axis_tdata;
      cnt     <= '0;
      res_pix <= '0;
      res_bad <= 1'b0;
    end
    case (state)
      S_RD_CHK: begin
        if (idx_bad) begin
          res_bad <= 1'b1;
        end
      end
      S_RD_LAT: begin
        res_pix <= mem_rdata;
      end
      S_BOX: begin
        x0 <= box_x0;
        x1 <= box_x1;
        y0 <= box_y0;
        y1 <= box_y1;
        k  <= '0;
      end
      S_SETUP: begin
        k <= k + 3'd1;
        // Products arrive in the cycle after their operands: E = P - Q per edge.
        if ((k != 3'd0) && (k != 3'd7)) begin
          if (kk[0]) begin
            e_row[e_idx] <= e_row[e_idx] - EW'(mac_p);
          end else begin
            e_row[e_idx] <= EW'(mac_p);
          end
        end
        if (k == 3'd7) begin
          row_start <= ADDR_W'(mac_p) + ADDR_W'(x0);
          pix_addr  <= ADDR_W'(mac_p) + ADDR_W'(x0);
          px        <= x0;
          py        <= y0;
          for (int i = 0; i < 3; i++) begin
            e_cur[i] <= e_row[i];
          end
        end
      end
      S_PIX: begin
        if (covered) begin
          ch <= '0;
        end
      end
      S_BLEND: begin
        ch <= ch + 3'd1;
        if ((ch != 3'd0) && (ch != 3'd4)) begin
          newpix[pc] <= bl_new;
        end
        if ((ch == 3'd4) && (cnt != '1)) begin
          cnt <= cnt + 1'b1;
        end
      end
      default: ;
    endcase
    // Walk the box: along the row, then to the start of the next row.
    if (advance && !(last_x && last_y)) begin
      if (last_x) begin
        px        <= x0;
        py        <= py + 1'b1;
        row_start <= row_start + ADDR_W'(w_eff);
        pix_addr  <= row_start + ADDR_W'(w_eff);
        for (int i = 0; i < 3; i++) begin
          e_row[i] <= e_row[i] + sy[i];
          e_cur[i] <= e_row[i] + sy[i];
        end
      end else begin
        px       <= px + 1'b1;
        pix_addr <= pix_addr + 1'b1;
        for (int i = 0; i < 3; i++) begin
          e_cur[i] <= e_cur[i] + sx[i];
        end
      end
    end
    if ((state == S_DONE) && out_free) begin
      m_axis_tdata <= trab_pkg::OUT_W'({cnt, res_pix});
      m_axis_tuser <= res_bad;
    end
  end

  // An accepted beat always starts work.
  `ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, state != S_IDLE,
               "accepted beat did not leave idle")
  // A pending result is never overwritten.
  `ASSERT_NEXT(a_result_held, (state == S_DONE) && m_axis_tvalid && !m_axis_tready,
               state == S_DONE, "result finished while output still full")
  // The walk stays inside the clamped box.
  `ASSERT_SAME(a_pix_in_box, state == S_PIX,
               (px >= x0) && (px <= x1) && (py >= y0) && (py <= y1),
               "pixel walk left the bounding box")
  // Every blended pixel is counted.
  `ASSERT_NEXT(a_count_follows_write, (state == S_BLEND) && (ch == 3'd4), cnt != '0,
               "blended pixel not counted")

endmodule

`default_nettype wire
